@@ design/text_console_char_engine_macros.svh @@
// ----------------------------------------------------------------------------
// text console char engine assertion macros
// shorthand for the concurrent checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH

// same-cycle implication, off during reset
`define TCCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after a reset cycle
`define TCCE_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

@@ design/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// shared types, codes and constants of the text console char engine
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // command queue between front and back
  localparam int Q_DEPTH = 4;

  // input modes
  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_SETCUR = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // control characters
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_RETURN    = 8'h0D;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] BLANK_CHAR     = 8'h20;

  localparam logic [6:0] RESET_ATTR = 7'h0F;
  localparam logic [3:0] FG_RESET   = 4'hF;
  localparam logic [2:0] BG_RESET   = 3'h0;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

  // classified operations
  typedef logic [2:0] op_t;
  localparam op_t OP_PRINT   = 3'd0;
  localparam op_t OP_NEWLINE = 3'd1;
  localparam op_t OP_RETURN  = 3'd2;
  localparam op_t OP_TAB     = 3'd3;
  localparam op_t OP_BKSP    = 3'd4;
  localparam op_t OP_CLEAR   = 3'd5;
  localparam op_t OP_SETCUR  = 3'd6;
  localparam op_t OP_READ    = 3'd7;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [6:0]  cell_attribute;
  } out_word_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
    logic       pos_ok;
  } cmd_t;

  typedef struct packed {
    logic [6:0] attr;
    logic [7:0] ch;
  } cell_t;

  // column modulo tab width for every 7-bit column, built by counting
  function automatic logic [127:0][3:0] tab_phase_table(input int tab_w);
    logic [127:0][3:0] t;
    int ph;
    ph = 0;
    for (int i = 0; i < 128; i++) begin
      t[i] = 4'(ph);
      if (ph == tab_w - 1) ph = 0;
      else ph = ph + 1;
    end
    return t;
  endfunction

endpackage

@@ design/tcce_queue.sv @@
// ----------------------------------------------------------------------------
// tcce_queue
// short command fifo between the classifier and the execution engine
// ----------------------------------------------------------------------------
module tcce_queue
  import tcce_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic not_empty
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  cmd_t          slot_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full      = (count_r == NW'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = PW'(wr_ptr_r + 1'b1);
    if (pop) rd_ptr_nxt = PW'(rd_ptr_r + 1'b1);
    if (push && !pop) count_nxt = NW'(count_r + 1'b1);
    else if (pop && !push) count_nxt = NW'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

@@ design/tcce_front.sv @@
// ----------------------------------------------------------------------------
// tcce_front
// input stage: takes words, decodes mode and control bytes, range-checks
// ----------------------------------------------------------------------------
module tcce_front
  import tcce_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     push,
  output cmd_t     push_cmd,
  input  logic     q_full
);

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_r;
  cmd_t cmd_nxt;
  logic take;

  assign push     = hold_valid_r && !q_full;
  assign in_stall = hold_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push_cmd = hold_r;

  always_comb begin
    cmd_nxt.char_code = in_data.char_code;
    cmd_nxt.row       = in_data.row;
    cmd_nxt.col       = in_data.col;
    cmd_nxt.pos_ok    = ({2'b00, in_data.row} < 7'(ROWS)) &&
                        ({1'b0, in_data.col} < 8'(COLUMNS));
    unique case (in_data.mode)
      MODE_PUT: begin
        priority case (in_data.char_code)
          CHAR_NEWLINE:   cmd_nxt.op = OP_NEWLINE;
          CHAR_RETURN:    cmd_nxt.op = OP_RETURN;
          CHAR_TAB:       cmd_nxt.op = OP_TAB;
          CHAR_BACKSPACE: cmd_nxt.op = OP_BKSP;
          default:        cmd_nxt.op = OP_PRINT;
        endcase
      end
      MODE_CLEAR:  cmd_nxt.op = OP_CLEAR;
      MODE_SETCUR: cmd_nxt.op = OP_SETCUR;
      MODE_READ:   cmd_nxt.op = OP_READ;
      default:     cmd_nxt.op = OP_READ;
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) hold_valid_nxt = 1'b1;
    else if (push) hold_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_valid_r <= 1'b0;
    else hold_valid_r <= hold_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) hold_r <= cmd_nxt;
  end

endmodule

@@ design/tcce_back.sv @@
// ----------------------------------------------------------------------------
// tcce_back
// execution engine: screen store, cursor, color registers, fill and scroll
// ----------------------------------------------------------------------------
module tcce_back
  import tcce_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [3:0]    PH_LAST   = 4'(TAB_WIDTH - 1);
  localparam logic [127:0][3:0] TAB_PHASE = tab_phase_table(TAB_WIDTH);

  localparam logic [2:0] S_FILL   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_TAB    = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  cell_t screen_mem [CELLS];
  cell_t mem_rdata_r;

  logic [2:0]    state_r, state_nxt;
  logic          init_r, init_nxt;
  logic [RW-1:0] cur_row_r, row_nxt;
  logic [CW-1:0] cur_col_r, col_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [3:0]    tab_ph_r, tab_ph_nxt;
  logic          copy_pend_r, copy_pend_nxt;
  logic [AW-1:0] copy_waddr_r, copy_waddr_nxt;
  logic          res_status_r, res_status_nxt;
  logic          res_rd_r, res_rd_nxt;
  logic [3:0]    fg_r, fg_nxt;
  logic [2:0]    bg_r, bg_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_r, out_nxt;

  logic          mem_we, mem_re, line_adv, slot_free;
  logic [AW-1:0] mem_waddr, mem_raddr, cur_addr;
  cell_t         mem_wdata;
  logic [6:0]    cur_attr;

  assign cur_attr  = {bg_r, fg_r};
  assign cur_addr  = AW'(AW'(cur_row_r) * COLS_A + AW'(cur_col_r));
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    row_nxt        = cur_row_r;
    col_nxt        = cur_col_r;
    ptr_nxt        = ptr_r;
    tab_ph_nxt     = tab_ph_r;
    copy_pend_nxt  = 1'b0;
    copy_waddr_nxt = copy_waddr_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    fg_nxt         = fg_r;
    bg_nxt         = bg_r;
    q_pop          = 1'b0;
    line_adv       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = '{attr: cur_attr, ch: BLANK_CHAR};
    mem_re         = 1'b0;
    mem_raddr      = ptr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;

    unique case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        if (init_r) mem_wdata.attr = RESET_ATTR;
        if (ptr_r == CELL_LAST) begin
          state_nxt = init_r ? S_IDLE : S_RESULT;
          init_nxt  = 1'b0;
        end else begin
          ptr_nxt = AW'(ptr_r + 1'b1);
        end
      end
      S_IDLE: begin
        if (q_not_empty && slot_free) begin
          q_pop          = 1'b1;
          res_status_nxt = 1'b0;
          res_rd_nxt     = 1'b0;
          state_nxt      = S_RESULT;
          unique case (q_cmd.op)
            OP_PRINT: begin
              mem_we         = 1'b1;
              mem_wdata.ch   = q_cmd.char_code;
              if (cur_col_r == LAST_COL) line_adv = 1'b1;
              else col_nxt = CW'(cur_col_r + 1'b1);
            end
            OP_NEWLINE: line_adv = 1'b1;
            OP_RETURN:  col_nxt = '0;
            OP_TAB: begin
              tab_ph_nxt = TAB_PHASE[7'(cur_col_r)];
              state_nxt  = S_TAB;
            end
            OP_BKSP: begin
              // step back one linear cell, staying put at the top-left corner
              mem_we = 1'b1;
              if (cur_col_r != '0) begin
                col_nxt   = CW'(cur_col_r - 1'b1);
                mem_waddr = AW'(cur_addr - 1'b1);
              end else if (cur_row_r != '0) begin
                row_nxt   = RW'(cur_row_r - 1'b1);
                col_nxt   = LAST_COL;
                mem_waddr = AW'(cur_addr - 1'b1);
              end
            end
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              ptr_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_SETCUR: begin
              if (q_cmd.pos_ok) begin
                row_nxt = RW'(q_cmd.row);
                col_nxt = CW'(q_cmd.col);
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            OP_READ: begin
              if (q_cmd.pos_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(AW'(q_cmd.row) * COLS_A + AW'(q_cmd.col));
                res_rd_nxt = 1'b1;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_TAB: begin
        mem_we = 1'b1;
        if (cur_col_r == LAST_COL) begin
          line_adv = 1'b1;
        end else begin
          col_nxt = CW'(cur_col_r + 1'b1);
          if (tab_ph_r == PH_LAST) state_nxt = S_RESULT;
          else tab_ph_nxt = 4'(tab_ph_r + 1'b1);
        end
      end
      S_SCROLL: begin
        // read one row ahead, write back in the following cycle
        mem_re         = 1'b1;
        copy_pend_nxt  = 1'b1;
        copy_waddr_nxt = AW'(ptr_r - COLS_A);
        if (ptr_r == CELL_LAST) state_nxt = S_DRAIN;
        else ptr_nxt = AW'(ptr_r + 1'b1);
      end
      S_DRAIN: begin
        ptr_nxt   = LAST_BASE;
        state_nxt = S_FILL;
      end
      S_RESULT: begin
        out_valid_nxt           = 1'b1;
        out_nxt.status          = res_status_r;
        out_nxt.cursor_row      = 5'(cur_row_r);
        out_nxt.cursor_col      = 7'(cur_col_r);
        out_nxt.cursor_position = 11'(cur_addr);
        out_nxt.cell_char       = res_rd_r ? mem_rdata_r.ch : '0;
        out_nxt.cell_attribute  = res_rd_r ? mem_rdata_r.attr : '0;
        state_nxt               = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (line_adv) begin
      col_nxt = '0;
      if (cur_row_r == LAST_ROW) begin
        ptr_nxt   = COLS_A;
        state_nxt = S_SCROLL;
      end else begin
        row_nxt   = RW'(cur_row_r + 1'b1);
        state_nxt = S_RESULT;
      end
    end

    if (copy_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = copy_waddr_r;
      mem_wdata = mem_rdata_r;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FG:  fg_nxt = cfg_wdata[3:0];
        REG_BG:  bg_nxt = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      init_r      <= 1'b1;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      ptr_r       <= '0;
      copy_pend_r <= 1'b0;
      fg_r        <= FG_RESET;
      bg_r        <= BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cur_row_r   <= row_nxt;
      cur_col_r   <= col_nxt;
      ptr_r       <= ptr_nxt;
      copy_pend_r <= copy_pend_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tab_ph_r     <= tab_ph_nxt;
    copy_waddr_r <= copy_waddr_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) screen_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_rdata_r <= screen_mem[mem_raddr];
  end

endmodule

@@ design/text_console_char_engine.sv @@
// ----------------------------------------------------------------------------
// text_console_char_engine
// text-mode terminal engine: screen store of char/attribute cells and cursor
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | command word (mode/char/pos)
//   output  | out_valid, out_stall, out_data | result word (status/cursor/cell)
//   config  | cfg_we, cfg_index, cfg_wdata   | color register write
//
// a word passes the input stage register and then the queue; the engine
// handles print, newline, return, backspace, set cursor and read straight
// from idle, a tab as a run of blank cells up to the tab stop, and a clear
// as a fill of every cell; a scroll copies each row up a row and blanks the
// last, all cell by cell through the single write and single read port of
// the screen store; after reset the engine fills all ROWS * COLUMNS cells
// (2000 at 80 x 25) before it takes a word from the queue; config writes go
// in anytime; out_stall holds the result register; the queue keeps accepting
// words until it fills, and only then in_stall rises
//
module text_console_char_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // classified command moving front -> queue -> back
  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t push_cmd, pop_cmd;

  // decode and range check
  tcce_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .push    (q_push),
    .push_cmd(push_cmd),
    .q_full  (q_full)
  );

  // lets the input side run ahead while a long fill or scroll is going on
  tcce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .not_empty(q_not_empty)
  );

  // screen store, cursor and sequencer for the multi-cell operations
  tcce_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ design/tcce_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_checker
// port-level checks on the result channel of the text console char engine
// ----------------------------------------------------------------------------
`include "text_console_char_engine_macros.svh"

module tcce_checker
  import tcce_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  `TCCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")

  `TCCE_ASSERT_NOW(a_err_no_cell, clk, rst_n, out_valid && out_data.status, (out_data.cell_char == 8'd0) && (out_data.cell_attribute == 7'd0), "cell fields set on a range error")

  `TCCE_ASSERT_NOW(a_col_range, clk, rst_n, out_valid, int'(out_data.cursor_col) < COLUMNS, "cursor column out of range")

  `TCCE_ASSERT_NOW(a_pos_match, clk, rst_n, out_valid && (ROWS <= 32), out_data.cursor_position == 11'(int'(out_data.cursor_row) * COLUMNS + int'(out_data.cursor_col)), "linear cursor position does not match row and column")

  `TCCE_ASSERT_AFTER_RESET(a_reset_quiet, clk, rst_n, !out_valid, "result valid right after reset")

endmodule

bind text_console_char_engine tcce_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcce_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ verif/char_engine_monitor.sv @@
// ----------------------------------------------------------------------------
// char_engine_monitor
// watches the command, result and color ports of the text console engine,
// keeps its own copy of the screen, cursor and colors, and checks each result
// word against the oldest predicted one
// ----------------------------------------------------------------------------
module char_engine_monitor
  import tcce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int COLS  = DEF_COLUMNS;
  localparam int ROWS  = DEF_ROWS;
  localparam int TABW  = DEF_TAB_WIDTH;
  localparam int CELLS = COLS * ROWS;

  cell_t       screen [CELLS];
  int unsigned crow;
  int unsigned ccol;
  logic [3:0]  fg;
  logic [2:0]  bg;
  out_word_t   due_results [$];
  int          errors;
  int          seen;

  function automatic logic [6:0] pen();
    return {bg, fg};
  endfunction

  function automatic void write_cell(logic [7:0] ch);
    screen[crow * COLS + ccol] = '{attr: pen(), ch: ch};
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '{attr: pen(), ch: BLANK_CHAR};
    crow = ROWS - 1;
    ccol = 0;
  endfunction

  function automatic void line_feed();
    ccol = 0;
    crow++;
    if (crow >= ROWS) scroll_up();
  endfunction

  function automatic void put_byte(logic [7:0] ch);
    int unsigned n;
    bit wrapped;
    wrapped = 1'b0;
    case (ch)
      CHAR_NEWLINE: line_feed();
      CHAR_RETURN: ccol = 0;
      CHAR_TAB: begin
        n = TABW - (ccol % TABW);
        for (int unsigned i = 0; i < n && !wrapped; i++) begin
          write_cell(BLANK_CHAR);
          ccol++;
          if (ccol >= COLS) begin
            line_feed();
            wrapped = 1'b1;
          end
        end
      end
      CHAR_BACKSPACE: begin
        // at column zero step back to the end of the row above, if any
        if (ccol > 0) begin
          ccol--;
        end else if (crow > 0) begin
          crow--;
          ccol = COLS - 1;
        end
        write_cell(BLANK_CHAR);
      end
      default: begin
        write_cell(ch);
        ccol++;
        if (ccol >= COLS) line_feed();
      end
    endcase
  endfunction

  function automatic out_word_t predict(in_word_t w);
    out_word_t r;
    logic      in_range;
    cell_t     c;
    r = '0;
    in_range = (w.row < ROWS) && (w.col < COLS);
    case (w.mode)
      MODE_PUT: put_byte(w.char_code);
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = '{attr: pen(), ch: BLANK_CHAR};
        crow = 0;
        ccol = 0;
      end
      MODE_SETCUR: begin
        if (in_range) begin
          crow = w.row;
          ccol = w.col;
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        if (in_range) begin
          c = screen[w.row * COLS + w.col];
          r.cell_char = c.ch;
          r.cell_attribute = c.attr;
        end else begin
          r.status = 1'b1;
        end
      end
    endcase
    r.cursor_row = 5'(crow);
    r.cursor_col = 7'(ccol);
    r.cursor_position = 11'(crow * COLS + ccol);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '{attr: RESET_ATTR, ch: BLANK_CHAR};
      crow = 0;
      ccol = 0;
      fg = FG_RESET;
      bg = BG_RESET;
      due_results.delete();
      errors = 0;
      seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FG: fg = cfg_wdata;
          REG_BG: bg = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          if (errors < 10)
            $display("result word %0d arrived with nothing outstanding: %p", seen, out_data);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.cursor_row !== want.cursor_row ||
              out_data.cursor_col !== want.cursor_col ||
              out_data.cursor_position !== want.cursor_position ||
              out_data.cell_char !== want.cell_char ||
              out_data.cell_attribute !== want.cell_attribute) begin
            if (errors < 10) begin
              $display("result word %0d wrong: expected st=%0d r=%0d c=%0d pos=%0d ch=%h at=%h",
                       seen, want.status, want.cursor_row, want.cursor_col,
                       want.cursor_position, want.cell_char, want.cell_attribute);
              $display("  got st=%0d r=%0d c=%0d pos=%0d ch=%h at=%h",
                       out_data.status, out_data.cursor_row, out_data.cursor_col,
                       out_data.cursor_position, out_data.cell_char,
                       out_data.cell_attribute);
            end
            errors++;
          end
        end
        seen++;
      end
      if (in_valid && !in_stall) due_results.push_back(predict(in_data));
    end
    fail_count <= errors;
    pending <= due_results.size();
  end

endmodule

@@ verif/text_console_char_engine_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_char_engine_tb
// drives command words and color writes into the text console engine with
// random gaps and result-side stalls; a separate monitor predicts and checks
// every result word, this top only makes stimulus and reports the verdict
// ----------------------------------------------------------------------------
module text_console_char_engine_tb;
  import tcce_pkg::*;

  localparam int COLS        = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  // slowest pass: every word a scroll or clear plus the longest gap and stall,
  // on top of the fill pass after reset; taken a few times over
  localparam int CYCLE_LIMIT = 20_000_000;
  // idle margin after the last result before the colors are rewritten
  localparam int SETTLE      = 4200;
  localparam int LONG_HOLD   = 400;

  // color register indexes that hold nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;     // no gaps on either side while set, bar a hold request
  bit hold_req = 1'b0;  // asks the result side for one long hold-off

  text_console_char_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  char_engine_monitor watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts, mostly short, some long, none when quiet;
  // a hold request turns into one long hold-off counted here
  initial begin : rx_side
    int stall_len;
    int run_len;
    int p;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall_len = LONG_HOLD;
        hold_req = 1'b0;
      end else if (quiet) begin
        stall_len = 0;
      end else begin
        p = $urandom_range(99);
        if (p < 50) stall_len = 0;
        else if (p < 85) stall_len = $urandom_range(3, 1);
        else if (p < 97) stall_len = $urandom_range(15, 4);
        else stall_len = $urandom_range(60, 20);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      run_len = quiet ? 16 : $urandom_range(6, 1);
      repeat (run_len) @(posedge clk);
    end
  end

  // offer one word after a random gap and hold it until taken
  task automatic send(input in_word_t w);
    int gap;
    int p;
    p = $urandom_range(99);
    if (quiet || p < 55) gap = 0;
    else if (p < 85) gap = $urandom_range(3, 1);
    else if (p < 97) gap = $urandom_range(12, 4);
    else gap = $urandom_range(60, 20);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // fields a mode does not use carry random bits
  function automatic in_word_t mk_word(logic [1:0] m, logic [7:0] ch,
                                       logic [4:0] r, logic [6:0] c);
    in_word_t w;
    w.mode = m;
    w.char_code = ch;
    w.row = r;
    w.col = c;
    return w;
  endfunction

  task automatic put(input logic [7:0] ch);
    send(mk_word(MODE_PUT, ch, 5'($urandom), 7'($urandom)));
  endtask

  task automatic setcur(input logic [4:0] r, input logic [6:0] c);
    send(mk_word(MODE_SETCUR, 8'($urandom), r, c));
  endtask

  task automatic read(input logic [4:0] r, input logic [6:0] c);
    send(mk_word(MODE_READ, 8'($urandom), r, c));
  endtask

  task automatic clear_screen();
    send(mk_word(MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)));
  endtask

  // sender pauses until every result is back and the engine has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called while the engine is idle
  task automatic set_colors(input logic [3:0] fgv, input logic [3:0] bgv);
    cfg_we <= 1'b1;
    cfg_index <= REG_FG;
    cfg_wdata <= fgv;
    @(posedge clk);
    cfg_index <= REG_BG;
    cfg_wdata <= bgv;
    @(posedge clk);
    // a write to an index with no register must change nothing
    cfg_index <= $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= 4'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly short runs of text after a cursor move, the rest raw noise words
  task automatic run_random(input int upto);
    in_word_t w;
    logic [7:0] ch;
    logic [6:0] c;
    int n;
    int p;
    while (sent < upto) begin
      if ($urandom_range(4) == 0) begin
        w = mk_word(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
        // clears walk the whole screen, keep them rare
        if (w.mode == MODE_CLEAR && $urandom_range(15) != 0) w.mode = MODE_READ;
        send(w);
      end else begin
        // start near the end of a row now and then so tabs and text wrap
        c = ($urandom_range(3) == 0) ? 7'(COLS - 1 - $urandom_range(9))
                                     : 7'($urandom_range(COLS - 1));
        // the bottom row only sometimes, since every wrap there scrolls
        if ($urandom_range(9) == 0) setcur(5'(ROWS - 1), c);
        else setcur(5'($urandom_range(ROWS - 3)), c);
        n = $urandom_range(14, 3);
        repeat (n) begin
          p = $urandom_range(99);
          if (p < 68) ch = 8'($urandom_range(126, 32));
          else if (p < 76) ch = 8'($urandom_range(255, 127));
          else if (p < 79) ch = 8'($urandom_range(31));
          else if (p < 85) ch = CHAR_TAB;
          else if (p < 90) ch = CHAR_BACKSPACE;
          else if (p < 93) ch = CHAR_RETURN;
          else if (p < 96) ch = CHAR_NEWLINE;
          else ch = 8'h00;
          if (p >= 96 && $urandom_range(1) == 0)
            read(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
          else
            put(ch);
        end
        read(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words with the reset colors
    read(5'd0, 7'd0);                       // untouched cell after reset
    read(5'(ROWS - 1), 7'(COLS - 1));
    put(8'h41);
    put(8'hFF);
    put(8'h00);
    put(CHAR_TAB);                          // column 3 to 8, blanks on the way
    read(5'd0, 7'd3);
    put(CHAR_RETURN);
    put(CHAR_NEWLINE);
    put(CHAR_BACKSPACE);                    // column zero wraps to the row above
    setcur(5'd0, 7'd0);
    put(CHAR_BACKSPACE);                    // top-left corner stays put
    setcur(5'(ROWS), 7'd5);                 // row out of range
    setcur(5'd3, 7'(COLS));                 // column out of range
    setcur(5'd31, 7'd127);
    read(5'd31, 7'd127);
    read(5'(ROWS), 7'd0);
    setcur(5'd0, 7'(COLS - 4));
    put(CHAR_TAB);                          // row fills before the tab stop
    setcur(5'(ROWS - 1), 7'(COLS - 1));
    put(8'h5A);                             // wrap at the last cell scrolls
    put(CHAR_NEWLINE);                      // newline on the last row scrolls
    read(5'(ROWS - 3), 7'(COLS - 1));
    clear_screen();
    read(5'(ROWS - 1), 7'd0);
    drain();

    // lowest colors
    set_colors(4'h0, 4'h0);
    clear_screen();
    run_random(350);
    drain();

    // highest colors, background given with its spare bit set;
    // long hold on the result side while words keep coming, no gaps
    set_colors(4'hF, 4'hF);
    quiet = 1'b1;
    hold_req = 1'b1;
    setcur(5'd5, 7'd0);
    repeat (60) put(8'($urandom_range(126, 33)));
    quiet = 1'b0;
    run_random(700);
    drain();

    // random colors, a long stretch without idling on either side
    set_colors(4'($urandom), 4'($urandom));
    clear_screen();
    quiet = 1'b1;
    run_random(1000);
    quiet = 1'b0;
    drain();

    set_colors(4'h7, 4'h0);
    run_random(1400);
    drain();

    set_colors(4'($urandom), 4'($urandom));
    clear_screen();
    run_random(1850);
    drain();

    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tcce_pkg.sv
design/tcce_queue.sv
design/tcce_front.sv
design/tcce_back.sv
design/text_console_char_engine.sv
design/tcce_checker.sv
verif/char_engine_monitor.sv
verif/text_console_char_engine_tb.sv
